[rtl/pas_pkg.sv]
// ----------------------------------------------------------------------------
// pas_pkg
// Shared types, constants and the arctangent table of the angle simplifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pas_pkg;

    // coordinate, difference and cordic datapath widths
    localparam int COORD_W = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int FRAC_X  = 8;
    localparam int VEC_W   = 36;
    localparam int ANG_W   = 26;
    localparam int DIR_W   = 16;
    localparam int TAB_W   = 22;

    // micro-rotation index covers the whole arctangent table
    localparam int TAB_DEPTH = 24;
    localparam int STEP_W    = 5;

    // quarter turn in extended angle units (binary angle times 256)
    localparam logic signed [ANG_W-1:0] QUARTER_TURN = ANG_W'(4194304);
    localparam logic signed [ANG_W-1:0] ROUND_HALF   = ANG_W'(128);

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROT,
        ST_DONE
    } pas_state_t;

    // outline tracking phase
    typedef enum logic [1:0] {
        PH_NONE,
        PH_ONE,
        PH_TRACK
    } pas_phase_t;

    // control from the sequencer to the cordic unit
    typedef struct packed {
        logic              load;
        logic              rotate;
        logic [STEP_W-1:0] step;
    } pas_cordic_ctl_t;

    // status from the tracking unit to the sequencer
    typedef struct packed {
        logic             skip_rot;
        logic             keep;
        logic [DIR_W-1:0] dir;
    } pas_trk_sts_t;

    // atan(2^-i) in units of 1/256 binary angle, rounded
    function automatic logic [TAB_W-1:0] atan_val(input logic [STEP_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = TAB_W'(2097152);
            5'd1:    v = TAB_W'(1238021);
            5'd2:    v = TAB_W'(654136);
            5'd3:    v = TAB_W'(332050);
            5'd4:    v = TAB_W'(166669);
            5'd5:    v = TAB_W'(83416);
            5'd6:    v = TAB_W'(41718);
            5'd7:    v = TAB_W'(20860);
            5'd8:    v = TAB_W'(10430);
            5'd9:    v = TAB_W'(5215);
            5'd10:   v = TAB_W'(2608);
            5'd11:   v = TAB_W'(1304);
            5'd12:   v = TAB_W'(652);
            5'd13:   v = TAB_W'(326);
            5'd14:   v = TAB_W'(163);
            5'd15:   v = TAB_W'(81);
            5'd16:   v = TAB_W'(41);
            5'd17:   v = TAB_W'(20);
            5'd18:   v = TAB_W'(10);
            5'd19:   v = TAB_W'(5);
            5'd20:   v = TAB_W'(3);
            5'd21:   v = TAB_W'(1);
            5'd22:   v = TAB_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/pas_cordic.sv]
// ----------------------------------------------------------------------------
// pas_cordic
// Vectoring cordic datapath: one micro-rotation per cycle on shared adders.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_cordic
    import pas_pkg::*;
(
    input  wire                             clk,
    input  wire pas_cordic_ctl_t            ctl,
    input  wire logic signed [DIFF_W-1:0]   dx,
    input  wire logic signed [DIFF_W-1:0]   dy,
    output logic signed [ANG_W-1:0]         z_out
);

    logic signed [VEC_W-1:0] x_reg, x_next;
    logic signed [VEC_W-1:0] y_reg, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;

    logic signed [VEC_W-1:0] dx_ext;
    logic signed [VEC_W-1:0] dy_ext;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;
    logic signed [ANG_W-1:0] a_ext;
    logic                    y_pos;

    // scaled differences
    assign dx_ext = {{(VEC_W-DIFF_W-FRAC_X){dx[DIFF_W-1]}}, dx, {FRAC_X{1'b0}}};
    assign dy_ext = {{(VEC_W-DIFF_W-FRAC_X){dy[DIFF_W-1]}}, dy, {FRAC_X{1'b0}}};

    // shifted terms and table angle for the current step
    assign xs    = x_reg >>> ctl.step;
    assign ys    = y_reg >>> ctl.step;
    assign a_ext = $signed({{(ANG_W-TAB_W){1'b0}}, atan_val(ctl.step)});
    assign y_pos = !y_reg[VEC_W-1] && (y_reg != '0);

    // load with quarter-turn prerotation, or one micro-rotation
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl.load)
        begin
            if (dx[DIFF_W-1])
            begin
                if (!dy[DIFF_W-1])
                begin
                    x_next = dy_ext;
                    y_next = -dx_ext;
                    z_next = QUARTER_TURN;
                end
                else
                begin
                    x_next = -dy_ext;
                    y_next = dx_ext;
                    z_next = -QUARTER_TURN;
                end
            end
            else
            begin
                x_next = dx_ext;
                y_next = dy_ext;
                z_next = '0;
            end
        end
        else if (ctl.rotate)
        begin
            if (y_pos)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + a_ext;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - a_ext;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign z_out = z_reg;

endmodule

`default_nettype wire

[rtl/pas_track.sv]
// ----------------------------------------------------------------------------
// pas_track
// Outline tracking: previous vertex, reference direction, threshold decision.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_track
    import pas_pkg::*;
(
    input  wire                             clk,
    input  wire                             rst_n,
    input  wire                             cfg_we,
    input  wire logic [DIR_W-1:0]           cfg_wdata,
    input  wire                             capture,
    input  wire logic [COORD_W-1:0]         cx,
    input  wire logic [COORD_W-1:0]         cy,
    input  wire                             first,
    input  wire                             commit,
    input  wire logic signed [ANG_W-1:0]    z_in,
    output logic signed [DIFF_W-1:0]        dx,
    output logic signed [DIFF_W-1:0]        dy,
    output pas_trk_sts_t                    sts
);

    logic [DIR_W-1:0]   min_delta_reg;
    logic [COORD_W-1:0] prev_x_reg;
    logic [COORD_W-1:0] prev_y_reg;
    logic [DIR_W-1:0]   ref_reg, ref_next;
    pas_phase_t         phase_reg, phase_next;
    logic [COORD_W-1:0] cur_x_reg;
    logic [COORD_W-1:0] cur_y_reg;
    logic               new_reg;
    logic               zero_reg;

    logic               start_new;
    logic signed [ANG_W-1:0] z_rnd;
    logic [DIR_W-1:0]   dir;
    logic [DIR_W-1:0]   diff;
    logic [DIR_W:0]     mag;
    logic               keep;

    // differences against the previous vertex
    assign dx = $signed({cx[COORD_W-1], cx}) - $signed({prev_x_reg[COORD_W-1], prev_x_reg});
    assign dy = $signed({cy[COORD_W-1], cy}) - $signed({prev_y_reg[COORD_W-1], prev_y_reg});
    assign start_new = first || (phase_reg == PH_NONE);

    // rounded direction, zero for a new outline or a repeated vertex
    assign z_rnd = z_in + ROUND_HALF;
    assign dir   = (new_reg || zero_reg) ? '0 : z_rnd[DIR_W+FRAC_X-1:FRAC_X];

    // wrapped difference magnitude against the reference
    assign diff = ref_reg - dir;
    assign mag  = diff[DIR_W-1] ? ((DIR_W+1)'(1 << DIR_W) - {1'b0, diff}) : {1'b0, diff};

    // keep decision and state update
    always_comb
    begin
        keep       = 1'b1;
        ref_next   = ref_reg;
        phase_next = phase_reg;
        if (new_reg)
        begin
            phase_next = PH_ONE;
        end
        else if (phase_reg == PH_ONE)
        begin
            ref_next   = dir;
            phase_next = PH_TRACK;
        end
        else if (mag < {1'b0, min_delta_reg})
        begin
            keep = 1'b0;
        end
        else
        begin
            ref_next = dir;
        end
    end

    assign sts.skip_rot = start_new;
    assign sts.keep     = keep;
    assign sts.dir      = dir;

    // control and tracking state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_delta_reg <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            ref_reg       <= '0;
            phase_reg     <= PH_NONE;
        end
        else
        begin
            if (cfg_we)
            begin
                min_delta_reg <= cfg_wdata;
            end
            if (commit)
            begin
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                ref_reg    <= ref_next;
                phase_reg  <= phase_next;
            end
        end
    end

    // captured vertex
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            cur_x_reg <= cx;
            cur_y_reg <= cy;
            new_reg   <= start_new;
            zero_reg  <= (dx == '0) && (dy == '0);
        end
    end

endmodule

`default_nettype wire

[rtl/polyline_angle_simplifier.sv]
// ----------------------------------------------------------------------------
// polyline_angle_simplifier
// Keep or drop decision for each outline vertex by segment direction change.
// ----------------------------------------------------------------------------
// Each vertex is loaded into the cordic, then runs min(CORDIC_STEPS,24)
// micro-rotations, one per cycle on the shared cordic adders, and ends
// with rounding and the threshold compare.
// The first vertex of an outline skips the rotations.
// The input is not ready while a vertex is in work; a finished result sits
// in the output register and the next vertex is taken while it waits.
// The user must write min_delta through cfg_we/cfg_wdata only while the block is idle (not enforced).
`default_nettype none

module polyline_angle_simplifier
    import pas_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire logic [15:0]    cfg_wdata,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [47:0]    s_axis_tdata,   // x_coord[23:0], y_coord[47:24]
    input  wire logic           s_axis_tuser,   // first_vertex
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [15:0]         m_axis_tdata,   // direction[15:0]
    output logic                m_axis_tuser    // keep
);

    localparam int NSTEPS = (CORDIC_STEPS > TAB_DEPTH) ? TAB_DEPTH : CORDIC_STEPS;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

    pas_state_t        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              ov_reg, ov_next;
    logic [DIR_W-1:0]  odir_reg;
    logic              okeep_reg;

    pas_cordic_ctl_t         cctl;
    pas_trk_sts_t            sts;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic signed [ANG_W-1:0]  z_val;
    logic                    in_xfer;
    logic                    commit;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        cctl.load   = 1'b0;
        cctl.rotate = 1'b0;
        cctl.step   = step_reg;
        commit      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (in_xfer)
                begin
                    cctl.load  = 1'b1;
                    state_next = sts.skip_rot ? ST_DONE : ST_ROT;
                end
            end
            ST_ROT:
            begin
                cctl.rotate = 1'b1;
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!ov_reg || m_axis_tready)
                begin
                    commit     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output valid
    always_comb
    begin
        ov_next = ov_reg;
        if (commit)
        begin
            ov_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            ov_reg    <= ov_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            odir_reg  <= sts.dir;
            okeep_reg <= sts.keep;
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = odir_reg;
    assign m_axis_tuser  = okeep_reg;

    pas_track u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .capture   (in_xfer),
        .cx        (s_axis_tdata[23:0]),
        .cy        (s_axis_tdata[47:24]),
        .first     (s_axis_tuser),
        .commit    (commit),
        .z_in      (z_val),
        .dx        (dx),
        .dy        (dy),
        .sts       (sts)
    );

    pas_cordic u_cordic (
        .clk   (clk),
        .ctl   (cctl),
        .dx    (dx),
        .dy    (dy),
        .z_out (z_val)
    );

endmodule

`default_nettype wire

[rtl/pas_checker.sv]
// ----------------------------------------------------------------------------
// pas_checker
// Port-level checks of the angle simplifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pas_checker
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 s_axis_tvalid,
    input  wire                 s_axis_tready,
    input  wire logic [47:0]    s_axis_tdata,
    input  wire logic           s_axis_tuser,
    input  wire                 m_axis_tvalid,
    input  wire                 m_axis_tready,
    input  wire logic [15:0]    m_axis_tdata,
    input  wire logic           m_axis_tuser
);

    // a vertex in work blocks the input for the next cycle
    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a new result appears only at the end of a vertex in work
    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a vertex in work");

    // a new result never directly follows an idle input with no result held
    a_no_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tready && !m_axis_tvalid) |=> !m_axis_tvalid || !$past(s_axis_tready)
            || $past(!s_axis_tvalid) == 1'b0)
        else $error("result appeared while idle");

    // a stalled result holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind polyline_angle_simplifier pas_checker u_pas_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polyline angle simplifier.
// ----------------------------------------------------------------------------
// Vertices go in as stream transfers and keep/direction verdicts come back.
// A scoreboard object runs its own bit-exact cordic and threshold tracking for
// every vertex it sees accepted. It compares each returned verdict with the
// oldest prediction. A directed opening covers coordinate extremes, zero
// vectors, half-turn deltas and the threshold corners. Random outlines follow
// under several thresholds and three source/sink stall patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import pas_pkg::*;

    localparam int ROT_STEPS  = 16;
    localparam int RUN_LIMIT  = 400000;
    localparam int PHASE_LEN  = 72;
    localparam int N_PHASES   = 9;

    // stall patterns, one per third of the random part
    typedef enum int {
        IDLE_SRC_LIGHT,
        IDLE_SINK_LIGHT,
        IDLE_NONE
    } idle_mode_t;

    // one predicted verdict
    typedef struct packed {
        logic        keep;
        logic [15:0] dir;
    } vertex_verdict_t;

    // ------------------------------------------------------------------------
    // predictor and verdict checker
    // ------------------------------------------------------------------------
    class vertex_scoreboard;
        longint          atan_lut[24];
        int unsigned     min_delta;
        logic [23:0]     last_x;
        logic [23:0]     last_y;
        logic [15:0]     ref_dir;
        pas_phase_t      trk;
        vertex_verdict_t verdicts[$];
        int              errors;
        int              n_vertices;
        int              n_checked;
        int              n_kept;
        int              n_settings;

        function new();
            atan_lut = '{2097152, 1238021, 654136, 332050, 166669, 83416, 41718,
                         20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
                         41, 20, 10, 5, 3, 1, 1, 0};
            min_delta  = 0;
            last_x     = '0;
            last_y     = '0;
            ref_dir    = '0;
            trk        = PH_NONE;
            errors     = 0;
            n_vertices = 0;
            n_checked  = 0;
            n_kept     = 0;
            n_settings = 0;
        endfunction

        function void set_threshold(input logic [15:0] v);
            min_delta = v;
            n_settings++;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        // binary angle of (dx, dy) by vectoring cordic, 8 extra fraction bits
        function logic [15:0] seg_angle(input longint dx, input longint dy);
            longint vx;
            longint vy;
            longint acc;
            longint sx;
            longint sy;
            longint t;
            int     steps;
            if (dx == 0 && dy == 0)
                return 16'd0;
            vx  = dx * 256;
            vy  = dy * 256;
            acc = 0;
            // fold the left half plane into the right one
            if (vx < 0)
            begin
                t = vx;
                if (vy >= 0)
                begin
                    vx  = vy;
                    vy  = -t;
                    acc = 16384 * 256;
                end
                else
                begin
                    vx  = -vy;
                    vy  = t;
                    acc = -16384 * 256;
                end
            end
            steps = (ROT_STEPS > 24) ? 24 : ROT_STEPS;
            for (int i = 0; i < steps; i++)
            begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy > 0)
                begin
                    vx  = vx + sy;
                    vy  = vy - sx;
                    acc = acc + atan_lut[i];
                end
                else
                begin
                    vx  = vx - sy;
                    vy  = vy + sx;
                    acc = acc - atan_lut[i];
                end
            end
            return 16'((acc + 128) >>> 8);
        endfunction

        // accepted vertex: advance tracking and queue the verdict
        function void note_vertex(input logic [23:0] x, input logic [23:0] y,
                                  input logic first);
            vertex_verdict_t v;
            longint          dx;
            longint          dy;
            logic [15:0]     d;
            int unsigned     mag;
            v.keep = 1'b1;
            v.dir  = '0;
            if (first || trk == PH_NONE)
                trk = PH_ONE;
            else
            begin
                dx    = longint'($signed(x)) - longint'($signed(last_x));
                dy    = longint'($signed(y)) - longint'($signed(last_y));
                v.dir = seg_angle(dx, dy);
                if (trk == PH_ONE)
                begin
                    ref_dir = v.dir;
                    trk     = PH_TRACK;
                end
                else
                begin
                    d   = ref_dir - v.dir;
                    mag = (d >= 16'd32768) ? 65536 - d : d;
                    if (mag < min_delta)
                        v.keep = 1'b0;
                    else
                        ref_dir = v.dir;
                end
            end
            last_x = x;
            last_y = y;
            n_vertices++;
            verdicts.insert(verdicts.size(), v);
        endfunction

        // returned verdict against the oldest prediction
        function void check_result(input logic [15:0] dir, input logic keep);
            vertex_verdict_t e;
            if (verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result dir=%0d keep=%0d",
                         $time, $signed(dir), keep);
                return;
            end
            e = verdicts[0];
            verdicts.delete(0);
            n_checked++;
            if (keep)
                n_kept++;
            if (e.keep !== keep)
            begin
                errors++;
                $display("%0t: keep mismatch, expected %0d actual %0d",
                         $time, e.keep, keep);
            end
            if (e.dir !== dir)
            begin
                errors++;
                $display("%0t: direction mismatch, expected %0d actual %0d",
                         $time, $signed(e.dir), $signed(dir));
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and instance
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // x_coord[23:0], y_coord[47:24]
    logic        s_axis_tuser;   // first_vertex
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;   // direction[15:0]
    logic        m_axis_tuser;   // keep

    int               src_gap_pct   = 0;
    int               sink_stall_pct = 0;
    int               cycle_cnt     = 0;
    vertex_scoreboard sb;

    polyline_angle_simplifier #(
        .CORDIC_STEPS (ROT_STEPS)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // cycle counter and watchdog
    initial
    begin
        while (cycle_cnt < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // sink back-pressure
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // ------------------------------------------------------------------------
    // drive tasks, all entered and left at a falling edge
    // ------------------------------------------------------------------------
    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SRC_LIGHT:
            begin
                src_gap_pct    = 6;
                sink_stall_pct = 46;
            end
            IDLE_SINK_LIGHT:
            begin
                src_gap_pct    = 46;
                sink_stall_pct = 6;
            end
            default:
            begin
                src_gap_pct    = 0;
                sink_stall_pct = 0;
            end
        endcase
    endtask

    task automatic send_vertex(input logic [23:0] x, input logic [23:0] y,
                               input logic first);
        // random source idle cycles before the transfer
        while ($urandom_range(0, 99) < src_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {y, x};
        s_axis_tuser  <= first;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_vertex(x, y, first);
        @(negedge clk);
    endtask

    // stop sending and wait for every verdict to come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_min_delta(input logic [15:0] v);
        wait_drained();
        cfg_wdata <= v;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_threshold(v);
    endtask

    // random outlines of near-collinear steps, with noise and short outlines
    task automatic random_outlines(input int n_items);
        int          sent;
        int          len;
        int          ux;
        int          uy;
        int          scale;
        int          jit;
        int          sx;
        int          sy;
        int          pick;
        logic [23:0] cx;
        logic [23:0] cy;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                // stray vertex anywhere in the coordinate space
                send_vertex(24'($urandom), 24'($urandom), 1'($urandom_range(0, 1)));
                sent++;
            end
            else
            begin
                len = $urandom_range(0, 14);
                if ($urandom_range(0, 3) == 0)
                begin
                    cx = 24'($urandom);
                    cy = 24'($urandom);
                end
                else
                begin
                    cx = 24'(int'($urandom_range(0, 200000)) - 100000);
                    cy = 24'(int'($urandom_range(0, 200000)) - 100000);
                end
                send_vertex(cx, cy, 1'b1);
                sent++;
                ux = int'($urandom_range(0, 600)) - 300;
                uy = int'($urandom_range(0, 600)) - 300;
                for (int k = 0; k < len && sent < n_items; k++)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                    begin
                        // sharp turn: new heading
                        ux = int'($urandom_range(0, 600)) - 300;
                        uy = int'($urandom_range(0, 600)) - 300;
                        sx = ux;
                        sy = uy;
                    end
                    else if (pick == 1)
                    begin
                        // repeated vertex
                        sx = 0;
                        sy = 0;
                    end
                    else if (pick == 2)
                    begin
                        sx = int'($urandom_range(0, 8388608)) - 4194304;
                        sy = int'($urandom_range(0, 8388608)) - 4194304;
                    end
                    else
                    begin
                        scale = $urandom_range(1, 4);
                        jit   = $urandom_range(0, 8);
                        sx    = ux * scale + int'($urandom_range(0, 2 * jit)) - jit;
                        sy    = uy * scale + int'($urandom_range(0, 2 * jit)) - jit;
                    end
                    cx = cx + 24'(sx);
                    cy = cy + 24'(sy);
                    send_vertex(cx, cy, 1'b0);
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] thr[N_PHASES];
        sb            = new();
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        set_idle(IDLE_SRC_LIGHT);

        // zero threshold: outline start without flag, zero vectors, extremes
        write_min_delta(16'd0);
        send_vertex(24'd0, 24'd0, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b0);
        send_vertex(24'h7FFFFF, 24'h7FFFFF, 1'b0);
        send_vertex(24'h800000, 24'h800000, 1'b0);
        send_vertex(24'h800000, 24'h7FFFFF, 1'b0);
        send_vertex(24'h7FFFFF, 24'h800000, 1'b0);
        send_vertex(24'h800000, 24'h800000, 1'b0);
        send_vertex(24'h7FFFFF, 24'h800000, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(-24'sd256, -24'sd1, 1'b0);

        // half-turn delta kept at threshold of half a turn, smaller turn dropped
        write_min_delta(16'd32768);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(24'd256, 24'd0, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b0);
        send_vertex(24'd0, 24'd1, 1'b0);

        // threshold beyond half a turn drops everything after the second vertex
        write_min_delta(16'hFFFF);
        send_vertex(24'd0, 24'd0, 1'b1);
        send_vertex(24'd100, 24'd0, 1'b0);
        send_vertex(24'd100, 24'd100, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b0);
        send_vertex(24'd0, 24'd0, 1'b0);
        send_vertex(24'h800000, 24'h7FFFFF, 1'b0);

        // random part across thresholds and stall patterns
        thr = '{16'd1, 16'd256, 16'd1024, 16'd4096, 16'($urandom_range(0, 32768)),
                16'd16384, 16'd32768, 16'd0, 16'($urandom_range(1, 4096))};
        for (int p = 0; p < N_PHASES; p++)
        begin
            set_idle(idle_mode_t'(p * 3 / N_PHASES));
            write_min_delta(thr[p]);
            random_outlines(PHASE_LEN);
        end

        wait_drained();
        repeat (30) @(negedge clk);

        $display("vertices sent %0d, verdicts checked %0d, kept %0d",
                 sb.n_vertices, sb.n_checked, sb.n_kept);
        $display("threshold settings %0d, cycles %0d, errors %0d",
                 sb.n_settings, cycle_cnt, sb.errors + sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
